>>> rtl/core/szt_pkg.sv
// Shared types and constants for the smallest-box zone table.
// Holds the item and result structs, the internal command format and the FSM state type.
// No dependencies.
package szt_pkg;

	localparam int COORD_BITS     = 16;
	localparam int WORD_BITS      = 16;
	localparam int ZONE_SLOTS_DEF = 64;
	localparam int OUT_SLOT_W     = 6;
	localparam int OUT_COUNT_W    = 7;
	localparam int QUEUE_DEPTH    = 2;
	localparam int AREA_W         = 2 * COORD_BITS;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_CLEAR,
		OP_QUERY,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} back_state_t;

	typedef struct packed {
		logic [1:0]                   mode;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_min_z;
		logic signed [COORD_BITS-1:0] box_max_z;
		logic [WORD_BITS-1:0]         param_0;
		logic [WORD_BITS-1:0]         param_1;
		logic [WORD_BITS-1:0]         param_2;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_z;
	} item_t;

	typedef struct packed {
		logic [OUT_SLOT_W-1:0]  added_slot;
		logic                   add_failed;
		logic                   zone_found;
		logic [WORD_BITS-1:0]   result_word_0;
		logic [WORD_BITS-1:0]   result_word_1;
		logic [WORD_BITS-1:0]   result_word_2;
		logic [OUT_COUNT_W-1:0] used_zones;
	} result_t;

	// One stored zone: bounds and words, as kept in the slot memory.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] min_x;
		logic signed [COORD_BITS-1:0] max_x;
		logic signed [COORD_BITS-1:0] min_z;
		logic signed [COORD_BITS-1:0] max_z;
		logic [WORD_BITS-1:0]         word_0;
		logic [WORD_BITS-1:0]         word_1;
		logic [WORD_BITS-1:0]         word_2;
	} entry_t;

	typedef struct packed {
		op_t                          op;
		entry_t                       zone;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_z;
	} cmd_t;

endpackage

>>> rtl/core/szt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module szt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/szt_front.sv
// Front end: takes items off the command port and classifies the mode into an operation.
// Depends on szt_pkg.
module szt_front (
	input  logic          start,
	input  logic          queue_full,
	input  szt_pkg::item_t item,
	output logic          busy,
	output logic          push,
	output szt_pkg::cmd_t cmd
);

	always_comb begin
		busy = queue_full;
		push = start && !queue_full;

		unique case (item.mode)
			szt_pkg::MODE_ADD:   cmd.op = szt_pkg::OP_ADD;
			szt_pkg::MODE_CLEAR: cmd.op = szt_pkg::OP_CLEAR;
			szt_pkg::MODE_QUERY: cmd.op = szt_pkg::OP_QUERY;
			default:             cmd.op = szt_pkg::OP_NOP;
		endcase

		cmd.zone.min_x  = item.box_min_x;
		cmd.zone.max_x  = item.box_max_x;
		cmd.zone.min_z  = item.box_min_z;
		cmd.zone.max_z  = item.box_max_z;
		cmd.zone.word_0 = item.param_0;
		cmd.zone.word_1 = item.param_1;
		cmd.zone.word_2 = item.param_2;
		cmd.point_x     = item.point_x;
		cmd.point_z     = item.point_z;
	end

endmodule

>>> rtl/core/szt_queue.sv
// Short command queue between the front end and the back end.
// Depends on szt_pkg.
module szt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  szt_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output szt_pkg::cmd_t head
);

	localparam int DEPTH = szt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	szt_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/core/szt_back.sv
// Back end: runs add, clear and query commands against the slot memory.
// Queries scan the used slots through a read/contain/multiply/compare pipeline.
// Depends on szt_pkg and szt_ram.
module szt_back #(
	parameter int ZONE_SLOTS = szt_pkg::ZONE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  szt_pkg::cmd_t    cmd,
	output logic             pop,
	output logic             done,
	output szt_pkg::result_t result
);

	localparam int ADDR_W  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
	localparam int CNT_W   = $clog2(ZONE_SLOTS + 1);
	localparam int CB      = szt_pkg::COORD_BITS;
	localparam int WB      = szt_pkg::WORD_BITS;
	localparam int ENTRY_W = $bits(szt_pkg::entry_t);

	szt_pkg::back_state_t state_q, state_d;
	szt_pkg::cmd_t        cmd_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_v_q;
	logic             full;
	logic             issue;
	logic             wr_en;
	logic             scan_done;

	logic [ENTRY_W-1:0] rd_data;
	szt_pkg::entry_t    ent;
	logic               contain;

	logic               v_s1;
	logic [CB-1:0]      ext_x_s1;
	logic [CB-1:0]      ext_z_s1;
	logic [WB-1:0]      w0_s1, w1_s1, w2_s1;

	logic                       v_s2;
	logic [szt_pkg::AREA_W-1:0] area_s2;
	logic [WB-1:0]              w0_s2, w1_s2, w2_s2;

	logic                       found_q;
	logic [szt_pkg::AREA_W-1:0] min_area_q;
	logic [WB-1:0]              best_w0_q, best_w1_q, best_w2_q;
	logic                       take_best;
	logic [CNT_W-1:0]           slot_q;
	logic                       failed_q;
	logic                       done_q;
	szt_pkg::result_t           result_q;

	szt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ZONE_SLOTS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (cmd_q.zone),
		.rd_en   (issue),
		.rd_addr (issue_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign ent  = szt_pkg::entry_t'(rd_data);
	assign full = (count_q == CNT_W'(ZONE_SLOTS));

	// Bounds are inclusive; an inverted box never contains a point.
	assign contain = (cmd_q.point_x >= ent.min_x) && (cmd_q.point_x <= ent.max_x) &&
	                 (cmd_q.point_z >= ent.min_z) && (cmd_q.point_z <= ent.max_z);

	// Strict less-than keeps the earlier, lower slot on equal areas.
	assign take_best = v_s2 && (!found_q || (area_s2 < min_area_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			szt_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = szt_pkg::ST_EXEC;
				end
			end
			szt_pkg::ST_EXEC: begin
				unique case (cmd_q.op) inside
					szt_pkg::OP_QUERY: state_d = szt_pkg::ST_SCAN;
					szt_pkg::OP_ADD, szt_pkg::OP_CLEAR, szt_pkg::OP_NOP:
						state_d = szt_pkg::ST_FINISH;
					default: state_d = szt_pkg::ST_FINISH;
				endcase
			end
			szt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = szt_pkg::ST_FINISH;
				end
			end
			szt_pkg::ST_FINISH: state_d = szt_pkg::ST_IDLE;
			default:            state_d = szt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == szt_pkg::ST_IDLE) && cmd_valid;
		issue     = (state_q == szt_pkg::ST_SCAN) && (issue_q < count_q);
		wr_en     = (state_q == szt_pkg::ST_EXEC) && (cmd_q.op == szt_pkg::OP_ADD) && !full;
		scan_done = !issue && !rd_v_q && !v_s1 && !v_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= szt_pkg::ST_IDLE;
			count_q  <= '0;
			issue_q  <= '0;
			rd_v_q   <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			found_q  <= 1'b0;
			slot_q   <= '0;
			failed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == szt_pkg::ST_FINISH);
			rd_v_q  <= issue;
			v_s1    <= rd_v_q && contain;
			v_s2    <= v_s1;

			if (pop) begin
				issue_q  <= '0;
				found_q  <= 1'b0;
				slot_q   <= '0;
				failed_q <= 1'b0;
			end
			if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (take_best) begin
				found_q <= 1'b1;
			end
			if (state_q == szt_pkg::ST_EXEC) begin
				if (cmd_q.op == szt_pkg::OP_CLEAR) begin
					count_q <= '0;
				end else if (cmd_q.op == szt_pkg::OP_ADD) begin
					if (full) begin
						failed_q <= 1'b1;
					end else begin
						slot_q  <= count_q;
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end

		// Contained boxes have max >= min, so the extents need no clamp here.
		ext_x_s1 <= $unsigned(ent.max_x) - $unsigned(ent.min_x);
		ext_z_s1 <= $unsigned(ent.max_z) - $unsigned(ent.min_z);
		w0_s1    <= ent.word_0;
		w1_s1    <= ent.word_1;
		w2_s1    <= ent.word_2;

		area_s2 <= szt_pkg::AREA_W'(ext_x_s1) * szt_pkg::AREA_W'(ext_z_s1);
		w0_s2   <= w0_s1;
		w1_s2   <= w1_s1;
		w2_s2   <= w2_s1;

		if (take_best) begin
			min_area_q <= area_s2;
			best_w0_q  <= w0_s2;
			best_w1_q  <= w1_s2;
			best_w2_q  <= w2_s2;
		end

		if (state_q == szt_pkg::ST_FINISH) begin
			result_q.added_slot    <= szt_pkg::OUT_SLOT_W'(slot_q);
			result_q.add_failed    <= failed_q;
			result_q.zone_found    <= found_q;
			result_q.result_word_0 <= found_q ? best_w0_q : '0;
			result_q.result_word_1 <= found_q ? best_w1_q : '0;
			result_q.result_word_2 <= found_q ? best_w2_q : '0;
			result_q.used_zones    <= szt_pkg::OUT_COUNT_W'(count_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/smallest_box_zone_table_unit.sv
// Top level of the smallest-box zone table: front end, command queue and back end.
// Depends on szt_pkg, szt_front, szt_queue and szt_back.
//
//   channel   ports                  transfer when
//   --------  ---------------------  ------------------------------------
//   command   start, busy, item      start high and busy low at the edge
//   result    done, result           done high at the edge (one cycle)
//
// Add, clear and an unused mode pass through the back end's exec and finish states; a query
// also scans the used slots between them, reading one slot per cycle from the slot memory.
// The queue takes up to two more commands while the back end works; busy is high only
// when it is full. After reset the table is empty and the unit accepts at once. The
// receiver cannot stall: each result is shown for exactly one cycle.
module smallest_box_zone_table_unit #(
	parameter int ZONE_SLOTS = szt_pkg::ZONE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  szt_pkg::item_t   item,
	output logic             done,
	output szt_pkg::result_t result
);

	logic          queue_full;
	logic          push;
	logic          pop;
	logic          cmd_valid;
	szt_pkg::cmd_t front_cmd;
	szt_pkg::cmd_t head_cmd;

	szt_front u_front (
		.start      (start),
		.queue_full (queue_full),
		.item       (item),
		.busy       (busy),
		.push       (push),
		.cmd        (front_cmd)
	);

	szt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (cmd_valid),
		.head      (head_cmd)
	);

	szt_back #(
		.ZONE_SLOTS(ZONE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule
